@@ rtl/integer_to_ascii_formatter_top_defines.svh @@
// assertion macros used by the port-level checker file
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define ITOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/itoa_fmt_pkg.sv @@
// types, character constants and digit helpers for the integer formatter
package itoa_fmt_pkg;

    typedef logic [7:0] t_char;
    typedef logic [3:0] t_digit;

    localparam logic [1:0]  KIND_SIGNED   = 2'd0;
    localparam logic [1:0]  KIND_UNSIGNED = 2'd1;

    localparam t_char CHAR_MINUS   = 8'h2d;
    localparam t_char CHAR_ZERO    = 8'h30;
    localparam t_char CHAR_LOWER_A = 8'h61;
    localparam t_char CHAR_UPPER_A = 8'h41;

    localparam int unsigned MAX_CHARS = 16;

    // ceil(2^35 / 10): x / 10 == (x * DIV10_RECIP) >> 35 for any 32-bit x
    localparam logic [31:0] DIV10_RECIP = 32'hcccc_cccd;
    localparam int unsigned DIV10_SHIFT = 35;

    function automatic t_char digit_to_char(input t_digit digit, input logic upper);
        t_char base;
        if (digit < t_digit'(10)) begin
            return CHAR_ZERO + t_char'(digit);
        end
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        return base + t_char'(digit) - t_char'(10);
    endfunction

endpackage

@@ rtl/integer_to_ascii_formatter_top.sv @@
// integer to ascii formatter: signed/unsigned decimal and hex, one char per word
//
//  channel   signals                               handshake
//  --------  ------------------------------------  ------------------------------
//  command   i_kind, i_upper_case, i_number        start high while busy low
//  result    o_text_char, o_last_char              o_valid strobe, one cycle each
//
// digits are produced least significant first into a 16-entry digit buffer,
// then read back out most significant first.
// decimal: a reciprocal multiply state, then a quotient/remainder state per digit;
// hex: one nibble per cycle; then one output char per cycle, '-' first if negative.
// synchronous active-low reset returns to idle; results cannot be stalled.
module integer_to_ascii_formatter_top #(
    parameter int unsigned HEX_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic        i_upper_case,
    input  logic [63:0] i_number,
    output logic        o_valid,
    output logic [7:0]  o_text_char,
    output logic        o_last_char
);
    import itoa_fmt_pkg::*;

    localparam logic [63:0] HexMask =
        (HEX_WIDTH >= 64) ? 64'hffff_ffff_ffff_ffff : ((64'd1 << HEX_WIDTH) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state      r_state;
    logic [63:0] r_val;
    logic [63:0] r_prod;
    logic        r_hex;
    logic        r_upper;
    logic        r_neg;
    logic [4:0]  r_cnt;
    t_digit      r_digits [MAX_CHARS];
    logic        r_valid;
    t_char       r_char;
    logic        r_last;

    logic [31:0] n_dec_mag;
    logic [63:0] n_prod;
    logic [28:0] n_quot;
    logic [31:0] n_quot10;
    logic [31:0] n_rem;
    t_digit      n_digit;
    logic [63:0] n_val;
    logic [4:0]  n_rd;

    // magnitude of the signed view; the most negative value wraps to itself
    assign n_dec_mag = i_number[31] ? (~i_number[31:0] + 32'd1) : i_number[31:0];

    // shared unit: one 32x32 multiply by the reciprocal of ten
    assign n_prod   = r_val[31:0] * DIV10_RECIP;
    assign n_quot   = r_prod[63:DIV10_SHIFT];
    assign n_quot10 = {n_quot, 3'b000} + {2'b00, n_quot, 1'b0};
    assign n_rem    = r_val[31:0] - n_quot10;

    always_comb begin
        if (r_hex) begin
            n_digit = r_val[3:0];
            n_val   = {4'b0000, r_val[63:4]};
        end else begin
            n_digit = n_rem[3:0];
            n_val   = {35'd0, n_quot};
        end
    end

    assign n_rd = r_cnt - 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_valid <= 1'b0;
                    if (start) begin
                        r_cnt   <= '0;
                        r_upper <= i_upper_case;
                        r_hex   <= i_kind[1];
                        r_neg   <= 1'b0;
                        if (i_kind[1]) begin
                            r_val   <= i_number & HexMask;
                            r_state <= ST_DIG;
                        end else if (i_kind == KIND_UNSIGNED) begin
                            r_val   <= {32'd0, i_number[31:0]};
                            r_state <= ST_MUL;
                        end else begin
                            r_val   <= {32'd0, n_dec_mag};
                            r_neg   <= i_number[31];
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_valid <= 1'b0;
                    r_prod  <= n_prod;
                    r_state <= ST_DIG;
                end
                ST_DIG: begin
                    r_valid <= 1'b0;
                    r_digits[r_cnt[3:0]] <= n_digit;
                    r_cnt <= r_cnt + 5'd1;
                    r_val <= n_val;
                    if (n_val == 64'd0) begin
                        r_state <= r_neg ? ST_SIGN : ST_EMIT;
                    end else begin
                        r_state <= r_hex ? ST_DIG : ST_MUL;
                    end
                end
                ST_SIGN: begin
                    r_valid <= 1'b1;
                    r_char  <= CHAR_MINUS;
                    r_last  <= 1'b0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    r_valid <= 1'b1;
                    r_char  <= digit_to_char(r_digits[n_rd[3:0]], r_upper);
                    r_last  <= (r_cnt == 5'd1);
                    r_cnt   <= n_rd;
                    if (r_cnt == 5'd1) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

endmodule

@@ rtl/itoa_fmt_checker.sv @@
// port-level checks for the integer formatter, bound to the top level
`include "integer_to_ascii_formatter_top_defines.svh"

module itoa_fmt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_last_char
);

    // an accepted command keeps the block busy
    `ITOA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

    // no stale word right after a command is taken
    `ITOA_ASSERT_NEXT(a_accept_quiet, start && !busy, !o_valid, "word shown after accept")

    // the words of one number come back to back
    `ITOA_ASSERT_NEXT(a_run_contig, o_valid && !o_last_char, o_valid, "gap inside a number")

    // a number still in flight keeps busy high
    `ITOA_ASSERT_NOW(a_run_busy, o_valid && !o_last_char, busy, "idle before last word")

endmodule

bind integer_to_ascii_formatter_top itoa_fmt_checker u_itoa_fmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_last_char (o_last_char)
);

@@ verif/integer_to_ascii_formatter_checker.sv @@
// checker for the integer formatter: predicts each number's text and compares every char word
`timescale 1ns / 1ps

module integer_to_ascii_formatter_checker #(
    parameter int unsigned HEX_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_kind,
    input  logic        i_upper_case,
    input  logic [63:0] i_number,
    input  logic        i_valid,
    input  logic [7:0]  i_text_char,
    input  logic        i_last_char,
    output int          o_fail_count,
    output int          o_pending
);
    import itoa_fmt_pkg::*;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_text_word;

    localparam logic [63:0] HEX_MASK =
        (HEX_WIDTH >= 64) ? 64'hffff_ffff_ffff_ffff : ((64'd1 << HEX_WIDTH) - 64'd1);

    t_text_word pending_chars[$];
    int         fail_total = 0;
    int         depth = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = depth;

    // appends the chars of one number, most significant first
    function automatic void queue_text(input logic [1:0] kind, input logic upper,
                                       input logic [63:0] number);
        t_char       text[$];
        t_text_word  word;
        logic [63:0] mag;
        logic [31:0] low;
        int unsigned radix;
        t_digit      digit;
        radix = 10;
        if (kind == KIND_UNSIGNED) begin
            mag = 64'(number[31:0]);
        end else if (kind == KIND_SIGNED) begin
            low = number[31:0];
            // most negative value negates onto itself, which is already 2^31
            if (low[31]) begin
                low = ~low + 32'd1;
            end
            mag = 64'(low);
        end else begin
            // both upper kinds decode as hex
            mag   = number & HEX_MASK;
            radix = 16;
        end
        do begin
            digit = t_digit'(mag % radix);
            mag   = mag / radix;
            if (digit < t_digit'(10)) begin
                text.push_front(CHAR_ZERO + t_char'(digit));
            end else begin
                text.push_front((upper ? CHAR_UPPER_A : CHAR_LOWER_A)
                                + t_char'(digit) - t_char'(10));
            end
        end while (mag != 0);
        if (kind == KIND_SIGNED && number[31]) begin
            text.push_front(CHAR_MINUS);
        end
        foreach (text[i]) begin
            word.ch   = text[i];
            word.last = (i == text.size() - 1);
            pending_chars.push_back(word);
        end
    endfunction

    always @(posedge i_clk) begin : check_words
        t_text_word want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected char word: expected none, actual %h last %b",
                             $time, i_text_char, i_last_char);
                    fail_total++;
                end else begin
                    want = pending_chars.pop_front();
                    if (want.ch !== i_text_char) begin
                        $display("%0t: text_char mismatch: expected %h, actual %h",
                                 $time, want.ch, i_text_char);
                        fail_total++;
                    end
                    if (want.last !== i_last_char) begin
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, want.last, i_last_char);
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                queue_text(i_kind, i_upper_case, i_number);
            end
        end
        depth <= pending_chars.size();
    end

endmodule

@@ verif/tb_integer_to_ascii_formatter_top.sv @@
// testbench top for the integer formatter: number stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter_top;
    import itoa_fmt_pkg::*;

    localparam logic [1:0] KIND_HEX     = 2'd2;
    localparam logic [1:0] KIND_HEX_ALT = 2'd3;
    localparam int         RANDOM_WORDS = 150;
    localparam int         TAIL_CYCLES  = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_kind = KIND_SIGNED;
    logic        i_upper_case = 1'b0;
    logic [63:0] i_number = 64'd0;
    logic        busy;
    logic        o_valid;
    logic [7:0]  o_text_char;
    logic        o_last_char;
    int          fail_count;
    int          chars_pending;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    integer_to_ascii_formatter_top #(
        .HEX_WIDTH(64)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_upper_case(i_upper_case),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    integer_to_ascii_formatter_checker #(
        .HEX_WIDTH(64)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_kind      (i_kind),
        .i_upper_case(i_upper_case),
        .i_number    (i_number),
        .i_valid     (o_valid),
        .i_text_char (o_text_char),
        .i_last_char (o_last_char),
        .o_fail_count(fail_count),
        .o_pending   (chars_pending)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] random_number();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return raw;
            1: return {raw[63:32], 32'($urandom_range(0, 20))};
            2: return {raw[63:32], 32'd0 - 32'($urandom_range(1, 20))};
            3: return raw >> $urandom_range(0, 63);
            default: return (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
        endcase
    endfunction

    // one edge first so the count already holds any word just accepted
    task automatic wait_drained();
        @(posedge i_clk);
        while (chars_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [1:0] kind, input logic upper,
                             input logic [63:0] number, input bit drain);
        int unsigned gap;
        start        <= 1'b1;
        i_kind       <= kind;
        i_upper_case <= upper;
        i_number     <= number;
        do @(posedge i_clk); while (busy);
        gap = drain ? 0 : idle_gap();
        if (drain || gap != 0) begin
            // junk on the fields while start is low
            start        <= 1'b0;
            i_kind       <= 2'($urandom);
            i_upper_case <= 1'($urandom);
            i_number     <= {$urandom, $urandom};
            if (drain) begin
                wait_drained();
            end else begin
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(KIND_SIGNED,   1'b0, 64'd0, 1'b0);
        send_word(KIND_SIGNED,   1'b1, 64'hffff_ffff_0000_0001, 1'b0);
        send_word(KIND_SIGNED,   1'b0, 64'h0000_0000_ffff_ffff, 1'b0);
        send_word(KIND_SIGNED,   1'b0, 64'h0000_0000_7fff_ffff, 1'b0);
        send_word(KIND_SIGNED,   1'b0, 64'hdead_beef_8000_0000, 1'b0);
        send_word(KIND_SIGNED,   1'b1, 64'h0000_0000_ffff_cfc7, 1'b0);
        send_word(KIND_UNSIGNED, 1'b0, 64'd0, 1'b0);
        send_word(KIND_UNSIGNED, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b0);
        send_word(KIND_UNSIGNED, 1'b0, 64'h0000_0000_3b9a_ca00, 1'b0);
        send_word(KIND_UNSIGNED, 1'b0, 64'h1234_5678_8000_0000, 1'b0);
        send_word(KIND_HEX,      1'b0, 64'd0, 1'b0);
        send_word(KIND_HEX,      1'b0, 64'hffff_ffff_ffff_ffff, 1'b0);
        send_word(KIND_HEX,      1'b1, 64'hffff_ffff_ffff_ffff, 1'b0);
        send_word(KIND_HEX,      1'b0, 64'hdead_beef_cafe_f00d, 1'b0);
        send_word(KIND_HEX,      1'b1, 64'hdead_beef_cafe_f00d, 1'b0);
        send_word(KIND_HEX,      1'b1, 64'd1, 1'b0);
        send_word(KIND_HEX,      1'b0, 64'h8000_0000_0000_0000, 1'b0);
        send_word(KIND_HEX,      1'b1, 64'h0000_0000_abcd_ef09, 1'b0);
        send_word(KIND_HEX_ALT,  1'b0, 64'h0123_4567_89ab_cdef, 1'b0);
        send_word(KIND_HEX_ALT,  1'b1, 64'hfedc_ba98_7654_3210, 1'b1);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_word(2'($urandom_range(0, 3)), 1'($urandom), random_number(),
                      n == 60 || n == 120);
        end

        start <= 1'b0;
        wait_drained();
        if (fail_count == 0) begin
            $display("integer_to_ascii_formatter_top test passed");
        end else begin
            $display("integer_to_ascii_formatter_top test failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("integer_to_ascii_formatter_top test failed");
        $finish;
    end

endmodule
